[hdl/bmtl_pkg.sv]
package bmtl_pkg;

    localparam int MAX_SPEED_POINTS = 32;
    localparam int MAX_LOAD_POINTS  = 32;
    localparam int CELL_DEPTH       = MAX_SPEED_POINTS * MAX_LOAD_POINTS;
    localparam int SP_AW            = $clog2(MAX_SPEED_POINTS);
    localparam int LD_AW            = $clog2(MAX_LOAD_POINTS);
    localparam int IX_AW            = (SP_AW > LD_AW) ? SP_AW : LD_AW;
    localparam int CELL_AW          = $clog2(CELL_DEPTH);

    localparam int LEN_W  = 6;
    localparam int VAL_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    localparam int CFG_IW = 1;

    localparam int NUM_W  = 2 * VAL_W;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_CELL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_SPEED  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WR_LOAD   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SPEED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LOAD    = 3'd2;
    localparam logic [STAT_W-1:0] ST_SPEED_ORDER = 3'd3;
    localparam logic [STAT_W-1:0] ST_LOAD_ORDER  = 3'd4;

    localparam logic [CFG_IW-1:0] REG_SPEED_LEN = 1'b0;
    localparam logic [CFG_IW-1:0] REG_LOAD_LEN  = 1'b1;

    // Clamp a length register into 1..maxlen
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W:0] maxlen);
        logic [LEN_W-1:0] r;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if ({1'b0, len} > maxlen) begin
            r = maxlen[LEN_W-1:0];
        end else begin
            r = len;
        end
        return r;
    endfunction

endpackage

[hdl/bmtl_div.sv]
module bmtl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bmtl_pkg::NUM_W-1:0]    i_dividend,
    input  logic [bmtl_pkg::VAL_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [bmtl_pkg::NUM_W-1:0]    o_quotient
);

    logic [bmtl_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_done;
    logic [bmtl_pkg::NUM_W-1:0]  r_quo;
    logic [bmtl_pkg::VAL_W-1:0]  r_rem;
    logic [bmtl_pkg::VAL_W-1:0]  r_den;
    logic [bmtl_pkg::VAL_W:0]    w_sh;
    logic                        w_ge;
    logic [bmtl_pkg::VAL_W:0]    w_diff;

    // one quotient bit per cycle, restoring
    assign w_sh   = {r_rem, r_quo[bmtl_pkg::NUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= bmtl_pkg::DCNT_W'(bmtl_pkg::NUM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == bmtl_pkg::DCNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[bmtl_pkg::NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[bmtl_pkg::VAL_W-1:0] : w_sh[bmtl_pkg::VAL_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/bilinear_map_table_lookup.sv]
// Channel  | Direction | Handshake                       | Carries
// ---------+-----------+---------------------------------+-------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready   | tuser: cmd; tdata: queries, indices, data
// m_axis   | out       | m_axis_tvalid / m_axis_tready   | tdata: lookup_result, status
// cfg      | in        | i_cfg_valid / o_cfg_ready       | register index, length value
//
// Lookup: scans each axis entry by entry (speed then load), then reads the four
// corner cells, then runs up to three interpolations, all on the shared 32-step
// restoring divider. Writes check the index and, for axis writes, the neighbour order.
// Reset (synchronous, active low) restores both lengths to 16; table contents are
// not cleared. Input is refused while a command is in work; the output register
// holds a result until taken, and the next command may be accepted meanwhile.
module bilinear_map_table_lookup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [79:0]: speed_query, load_query, speed_index, load_index, write_data
    input  logic [5*bmtl_pkg::VAL_W-1:0]        s_axis_tdata,
    // [1:0]: cmd
    input  logic [bmtl_pkg::CMD_W-1:0]          s_axis_tuser,
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] lookup_result, [18:16] status, [23:19] zero
    output logic [23:0]                         m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmtl_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [bmtl_pkg::LEN_W-1:0]          i_cfg_data
);

    localparam int VW = bmtl_pkg::VAL_W;
    localparam int AW = bmtl_pkg::IX_AW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;   // axis read in flight
    localparam logic [3:0] S_SCMP  = 4'd2;   // compare axis entry with query
    localparam logic [3:0] S_CRD   = 4'd3;   // corner cell read in flight
    localparam logic [3:0] S_CCAP  = 4'd4;   // capture corner cell
    localparam logic [3:0] S_IMUL  = 4'd5;
    localparam logic [3:0] S_IDIV  = 4'd6;
    localparam logic [3:0] S_IWAIT = 4'd7;
    localparam logic [3:0] S_IFIN  = 4'd8;
    localparam logic [3:0] S_WCHK  = 4'd9;
    localparam logic [3:0] S_WPRV  = 4'd10;
    localparam logic [3:0] S_WNXT  = 4'd11;
    localparam logic [3:0] S_WLST  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state;

    logic [bmtl_pkg::LEN_W-1:0] r_slen_cfg, r_llen_cfg;
    logic [bmtl_pkg::LEN_W-1:0] w_slen, w_llen;

    logic [bmtl_pkg::CMD_W-1:0] r_cmd;
    logic [VW-1:0] r_sq, r_lq, r_si, r_li, r_wd;

    // storage
    logic [VW-1:0] speed_axis [bmtl_pkg::MAX_SPEED_POINTS];
    logic [VW-1:0] load_axis  [bmtl_pkg::MAX_LOAD_POINTS];
    logic [VW-1:0] cell_store [bmtl_pkg::CELL_DEPTH];
    logic [VW-1:0] r_sp_q, r_ld_q, r_cell_q;

    logic          r_sel;      // 0 scanning speed, 1 scanning load
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_slo_i, r_shi_i, r_llo_i, r_lhi_i;
    logic [VW-1:0] r_svlo, r_svhi, r_lvlo, r_lvhi;
    logic [1:0]    r_k;
    logic [VW-1:0] r_c [4];
    logic [1:0]    r_step;
    logic signed [2*VW+1:0] r_prod;
    logic [VW-1:0] r_den;
    logic [VW-1:0] r_rlo, r_rhi, r_res;
    logic [bmtl_pkg::STAT_W-1:0] r_status;

    logic          r_ovalid;
    logic [VW-1:0] r_ores;
    logic [bmtl_pkg::STAT_W-1:0] r_ostat;

    // scan operands
    logic [VW-1:0]  w_ax_q, w_q;
    logic [AW-1:0]  w_len_m1;
    // cell address
    logic [AW-1:0]  w_cs, w_cl;
    logic [bmtl_pkg::LEN_W+AW-1:0] w_cprod;
    logic [bmtl_pkg::CELL_AW-1:0]  w_caddr;
    logic           w_cell_we, w_sp_we, w_ld_we;
    // interpolation operands
    logic [VW-1:0]  w_a, w_b, w_iq, w_ilo, w_ihi;
    logic signed [VW:0] w_dab, w_dq;
    logic [2*VW+1:0] w_abs;
    logic            w_div_start, w_div_done;
    logic [bmtl_pkg::NUM_W-1:0] w_quo;
    logic [VW-1:0]  w_fin;
    // write checks
    logic           w_is_speed;
    logic [VW-1:0]  w_wix;
    logic [bmtl_pkg::LEN_W-1:0] w_wlen;
    logic [AW-1:0]  w_wlen_m1;

    assign w_slen = bmtl_pkg::clamp_len(r_slen_cfg,
                                        (bmtl_pkg::LEN_W+1)'(bmtl_pkg::MAX_SPEED_POINTS));
    assign w_llen = bmtl_pkg::clamp_len(r_llen_cfg,
                                        (bmtl_pkg::LEN_W+1)'(bmtl_pkg::MAX_LOAD_POINTS));

    // configuration: always ready, take effect on transfer
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slen_cfg <= bmtl_pkg::LEN_W'(16);
            r_llen_cfg <= bmtl_pkg::LEN_W'(16);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmtl_pkg::REG_SPEED_LEN: r_slen_cfg <= i_cfg_data;
                bmtl_pkg::REG_LOAD_LEN:  r_llen_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // axis scan operands
    assign w_ax_q   = r_sel ? r_ld_q : r_sp_q;
    assign w_q      = r_sel ? r_lq : r_sq;
    assign w_len_m1 = r_sel ? AW'(w_llen - 1'b1) : AW'(w_slen - 1'b1);

    // cell address: load length times speed position plus load position
    always_comb begin
        if (r_state == S_WCHK) begin
            w_cs = r_si[AW-1:0];
            w_cl = r_li[AW-1:0];
        end else begin
            w_cs = r_k[1] ? r_shi_i : r_slo_i;
            w_cl = r_k[0] ? r_lhi_i : r_llo_i;
        end
    end
    assign w_cprod = w_llen * w_cs;
    assign w_caddr = bmtl_pkg::CELL_AW'(w_cprod + (bmtl_pkg::LEN_W+AW)'(w_cl));

    // write checks
    assign w_is_speed = (r_cmd == bmtl_pkg::CMD_WR_SPEED);
    assign w_wix      = w_is_speed ? r_si : r_li;
    assign w_wlen     = w_is_speed ? w_slen : w_llen;
    assign w_wlen_m1  = AW'(w_wlen - 1'b1);

    assign w_cell_we = (r_state == S_WCHK) && (r_cmd == bmtl_pkg::CMD_WR_CELL)
                       && (r_si < VW'(w_slen)) && (r_li < VW'(w_llen));
    assign w_sp_we = (r_state == S_WLST) && w_is_speed
                     && !((w_wix[AW-1:0] < w_wlen_m1) && (r_wd > r_sp_q));
    assign w_ld_we = (r_state == S_WLST) && !w_is_speed
                     && !((w_wix[AW-1:0] < w_wlen_m1) && (r_wd > r_ld_q));

    // memories: registered reads
    always_ff @(posedge i_clk) begin
        if (w_sp_we) begin
            speed_axis[w_wix[bmtl_pkg::SP_AW-1:0]] <= r_wd;
        end
        r_sp_q <= speed_axis[r_idx[bmtl_pkg::SP_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_we) begin
            load_axis[w_wix[bmtl_pkg::LD_AW-1:0]] <= r_wd;
        end
        r_ld_q <= load_axis[r_idx[bmtl_pkg::LD_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            cell_store[w_caddr] <= r_wd;
        end
        r_cell_q <= cell_store[w_caddr];
    end

    // interpolation operands per step: low row, high row, then across speed
    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_a = r_c[0]; w_b = r_c[1]; w_iq = r_lq; w_ilo = r_lvlo; w_ihi = r_lvhi;
            end
            2'd1: begin
                w_a = r_c[2]; w_b = r_c[3]; w_iq = r_lq; w_ilo = r_lvlo; w_ihi = r_lvhi;
            end
            default: begin
                w_a = r_rlo; w_b = r_rhi; w_iq = r_sq; w_ilo = r_svlo; w_ihi = r_svhi;
            end
        endcase
    end

    assign w_dab = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
    assign w_dq  = $signed({1'b0, VW'(w_iq - w_ilo)});
    assign w_abs = r_prod[2*VW+1] ? (2*VW+2)'(-r_prod) : r_prod;
    assign w_div_start = (r_state == S_IDIV);
    assign w_fin = r_prod[2*VW+1] ? VW'(w_a - w_quo[VW-1:0]) : VW'(w_a + w_quo[VW-1:0]);

    bmtl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs[bmtl_pkg::NUM_W-1:0]),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= (s_axis_tuser == bmtl_pkg::CMD_LOOKUP) ? S_SRD : S_WCHK;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    // stop on first entry above or equal to query, or at the end
                    if (w_ax_q >= w_q || r_idx == w_len_m1) begin
                        r_state <= r_sel ? S_CRD : S_SRD;
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_CRD: r_state <= S_CCAP;
                S_CCAP: r_state <= (r_k == 2'd3) ? S_IMUL : S_CRD;
                S_IMUL: begin
                    if (w_ihi == w_ilo) begin
                        r_state <= (r_step == 2'd2) ? S_DONE : S_IMUL;
                    end else begin
                        r_state <= S_IDIV;
                    end
                end
                S_IDIV:  r_state <= S_IWAIT;
                S_IWAIT: if (w_div_done) r_state <= S_IFIN;
                S_IFIN:  r_state <= (r_step == 2'd2) ? S_DONE : S_IMUL;
                S_WCHK: begin
                    if (r_cmd == bmtl_pkg::CMD_WR_CELL || w_wix >= VW'(w_wlen)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WPRV;
                    end
                end
                S_WPRV: r_state <= S_WNXT;
                S_WNXT: begin
                    if (w_wix != '0 && (w_is_speed ? r_sp_q : r_ld_q) > r_wd) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WLST;
                    end
                end
                S_WLST: r_state <= S_DONE;
                S_DONE: if (!r_ovalid || m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd    <= s_axis_tuser;
                r_sq     <= s_axis_tdata[0*VW +: VW];
                r_lq     <= s_axis_tdata[1*VW +: VW];
                r_si     <= s_axis_tdata[2*VW +: VW];
                r_li     <= s_axis_tdata[3*VW +: VW];
                r_wd     <= s_axis_tdata[4*VW +: VW];
                r_sel    <= 1'b0;
                r_idx    <= '0;
                r_k      <= '0;
                r_step   <= '0;
                r_status <= bmtl_pkg::ST_OK;
                r_res    <= '0;
            end
            S_SCMP: begin
                if (w_ax_q < w_q && r_idx != w_len_m1) begin
                    // still below the query: advance the low bracket
                    if (r_sel) begin r_lvlo <= w_ax_q; r_llo_i <= r_idx; end
                    else       begin r_svlo <= w_ax_q; r_slo_i <= r_idx; end
                end else if (w_ax_q <= w_q) begin
                    // equal entry, or last entry still below: both brackets here
                    if (r_sel) begin
                        r_lvlo <= w_ax_q; r_llo_i <= r_idx;
                        r_lvhi <= w_ax_q; r_lhi_i <= r_idx;
                    end else begin
                        r_svlo <= w_ax_q; r_slo_i <= r_idx;
                        r_svhi <= w_ax_q; r_shi_i <= r_idx;
                    end
                end else begin
                    // first entry above; with nothing below, the low bracket is entry 0
                    if (r_sel) begin
                        r_lvhi <= w_ax_q; r_lhi_i <= r_idx;
                        if (r_idx == '0) begin r_lvlo <= w_ax_q; r_llo_i <= '0; end
                    end else begin
                        r_svhi <= w_ax_q; r_shi_i <= r_idx;
                        if (r_idx == '0) begin r_svlo <= w_ax_q; r_slo_i <= '0; end
                    end
                end
                // advance, or switch to the load axis
                if (w_ax_q >= w_q || r_idx == w_len_m1) begin
                    r_sel <= 1'b1;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_CCAP: begin
                r_c[r_k] <= r_cell_q;
                r_k      <= r_k + 1'b1;
            end
            S_IMUL: begin
                r_prod <= w_dab * w_dq;
                r_den  <= VW'(w_ihi - w_ilo);
                if (w_ihi == w_ilo) begin
                    // clamped or exact hit: take the low value
                    unique case (r_step)
                        2'd0:    r_rlo <= w_a;
                        2'd1:    r_rhi <= w_a;
                        default: r_res <= w_a;
                    endcase
                    r_step <= r_step + 1'b1;
                end
            end
            S_IFIN: begin
                unique case (r_step)
                    2'd0:    r_rlo <= w_fin;
                    2'd1:    r_rhi <= w_fin;
                    default: r_res <= w_fin;
                endcase
                r_step <= r_step + 1'b1;
            end
            S_WCHK: begin
                if (r_cmd == bmtl_pkg::CMD_WR_CELL) begin
                    if (r_si >= VW'(w_slen)) begin
                        r_status <= bmtl_pkg::ST_BAD_SPEED;
                    end else if (r_li >= VW'(w_llen)) begin
                        r_status <= bmtl_pkg::ST_BAD_LOAD;
                    end
                end else if (w_wix >= VW'(w_wlen)) begin
                    r_status <= w_is_speed ? bmtl_pkg::ST_BAD_SPEED : bmtl_pkg::ST_BAD_LOAD;
                end
                r_idx <= w_wix[AW-1:0] - 1'b1;   // lower neighbor
            end
            S_WPRV: r_idx <= w_wix[AW-1:0] + 1'b1;   // upper neighbor
            S_WNXT: begin
                if (w_wix != '0 && (w_is_speed ? r_sp_q : r_ld_q) > r_wd) begin
                    r_status <= w_is_speed ? bmtl_pkg::ST_SPEED_ORDER
                                           : bmtl_pkg::ST_LOAD_ORDER;
                end
            end
            S_WLST: begin
                if ((w_wix[AW-1:0] < w_wlen_m1) && (r_wd > (w_is_speed ? r_sp_q : r_ld_q))) begin
                    r_status <= w_is_speed ? bmtl_pkg::ST_SPEED_ORDER
                                           : bmtl_pkg::ST_LOAD_ORDER;
                end
            end
            default: ;
        endcase
    end

    // output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ores  <= r_res;
            r_ostat <= r_status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ostat, r_ores};

endmodule
